### hdl/ppdd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the pointing pose dwell detector.
// No dependencies; imported by ppdd_isqrt and pointing_pose_dwell_detector.
package ppdd_pkg;

  // Field and datapath widths
  localparam int COORD_W    = 24;              // Q12.12 features and positions
  localparam int MAG_W      = 24;              // magnitude of a position difference
  localparam int SQ_W       = 2 * MAG_W;       // one squared difference
  localparam int RAD_W      = SQ_W + 2;        // sum of three squares
  localparam int ROOT_W     = RAD_W / 2;       // integer square root
  localparam int SUM_W      = 32;              // saturating movement sum
  localparam int CNT_W      = 9;               // run counter
  localparam int CNT_THR_W  = 8;               // frame count threshold
  localparam int STILL_W    = 23;              // stillness threshold
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 24;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_HAND_HIP  = 2'd0,
    CFG_ELBOW     = 2'd1,
    CFG_FRAME_CNT = 2'd2,
    CFG_STILL     = 2'd3
  } cfg_idx_e;

  // Sequencer states of the top level
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SQUARE,
    ST_ROOT,
    ST_DECIDE,
    ST_RESULT
  } state_e;

  // Status of the square-root unit
  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

### hdl/pointing_pose_dwell_detector.sv
`timescale 1ns / 1ps
// Pointing pose dwell detector: one request at a time, one result per request.
// Steps per request: check and result for an empty or failing frame; check, decide and
// result for the first frame of a run; check, 4 multiply steps, the square-root unit,
// decide and result for a later qualifying frame. A new request waits for the last result.
// Reset: counter and movement sum clear, thresholds return to defaults, no output.
// Depends on ppdd_pkg and ppdd_isqrt.
module pointing_pose_dwell_detector #(
  parameter int FRACTION_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Frame stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: hand_hip_distance, elbow_angle, hand_x, hand_y, hand_z (24 bits each)
  input  logic [119:0] s_axis_tdata_i,
  // tuser: frame_empty
  input  logic        s_axis_tuser_i,
  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: detected (1), run_length (9), zero fill (6)
  output logic [15:0] m_axis_tdata_o,
  // Configuration writes
  input  logic                               cfg_we_i,
  input  logic [ppdd_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [ppdd_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import ppdd_pkg::*;

  localparam logic [STILL_W-1:0] STILL_RST = STILL_W'((45 << FRACTION_BITS) / 100);

  // Configuration registers
  logic signed [COORD_W-1:0] hh_thr_q, ea_thr_q;
  logic [CNT_THR_W-1:0]      cnt_thr_q;
  logic [STILL_W-1:0]        still_thr_q;

  // Sequencer and state
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   run_count_q, run_count_d;
  logic [SUM_W-1:0]   motion_sum_q, motion_sum_d;
  logic [1:0]         step_q, step_d;
  logic               det_q, det_d;
  logic               out_valid_q, out_valid_d;
  logic               out_load;
  logic               out_det_q;
  logic [CNT_W-1:0]   out_len_q;

  // Latched frame and last position
  logic                      empty_q;
  logic signed [COORD_W-1:0] hh_q, ea_q, px_q, py_q, pz_q;
  logic signed [COORD_W-1:0] last_x_q, last_y_q, last_z_q;

  // Square and root datapath
  logic signed [COORD_W-1:0] cur_pos, old_pos;
  logic signed [COORD_W:0]   diff;
  logic [COORD_W:0]          mag;
  logic [SQ_W-1:0]           prod_q;
  logic [RAD_W-1:0]          acc_q, acc_d;
  logic                      sqrt_start;
  logic [ROOT_W-1:0]         root;
  sqrt_stat_t                sq_stat;
  logic [SUM_W:0]            sum_ext;
  logic                      s_accept;
  logic                      qualify;

  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign qualify  = (hh_q > hh_thr_q) && (ea_q > ea_thr_q);

  // Pick the axis for this multiply step and take the magnitude of the difference
  always_comb begin
    case (step_q)
      2'd0: begin
        cur_pos = px_q;
        old_pos = last_x_q;
      end
      2'd1: begin
        cur_pos = py_q;
        old_pos = last_y_q;
      end
      default: begin
        cur_pos = pz_q;
        old_pos = last_z_q;
      end
    endcase
    diff = (COORD_W+1)'(cur_pos) - (COORD_W+1)'(old_pos);
    mag  = diff[COORD_W] ? (COORD_W+1)'(-diff) : diff;
  end

  // Sequencer: next state, counters and result
  always_comb begin
    state_d      = state_q;
    run_count_d  = run_count_q;
    motion_sum_d = motion_sum_q;
    step_d       = step_q;
    det_d        = det_q;
    acc_d        = acc_q;
    sqrt_start   = 1'b0;
    out_load     = 1'b0;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    sum_ext      = {1'b0, motion_sum_q} + (SUM_W+1)'(root);
    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        det_d = 1'b0;
        if (empty_q) begin
          state_d = ST_RESULT;
        end else if (!qualify) begin
          run_count_d  = '0;
          motion_sum_d = '0;
          state_d      = ST_RESULT;
        end else begin
          run_count_d = run_count_q + 1'b1;
          step_d      = '0;
          state_d     = (run_count_q != '0) ? ST_SQUARE : ST_DECIDE;
        end
      end
      ST_SQUARE: begin
        // Clear at step 0, else accumulate the product of the previous step
        acc_d  = (step_q == 2'd0) ? '0 : acc_q + RAD_W'(prod_q);
        step_d = step_q + 1'b1;
        if (step_q == 2'd3) begin
          sqrt_start = 1'b1;
          state_d    = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sq_stat.done) begin
          motion_sum_d = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
          state_d      = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (run_count_q > CNT_W'(cnt_thr_q)) begin
          det_d        = motion_sum_q < SUM_W'(still_thr_q);
          run_count_d  = '0;
          motion_sum_d = '0;
        end
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        // Wait until the output register is free
        if (!out_valid_q || m_axis_tready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      run_count_q  <= '0;
      motion_sum_q <= '0;
      step_q       <= '0;
      det_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      run_count_q  <= run_count_d;
      motion_sum_q <= motion_sum_d;
      step_q       <= step_d;
      det_q        <= det_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hh_thr_q    <= '0;
      ea_thr_q    <= '0;
      cnt_thr_q   <= '0;
      still_thr_q <= STILL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_HAND_HIP:  hh_thr_q    <= cfg_data_i;
        CFG_ELBOW:     ea_thr_q    <= cfg_data_i;
        CFG_FRAME_CNT: cnt_thr_q   <= cfg_data_i[CNT_THR_W-1:0];
        CFG_STILL:     still_thr_q <= cfg_data_i[STILL_W-1:0];
        default: ;
      endcase
    end
  end

  // Payload registers: latched frame, last position, products, output
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      empty_q <= s_axis_tuser_i;
      hh_q    <= s_axis_tdata_i[23:0];
      ea_q    <= s_axis_tdata_i[47:24];
      px_q    <= s_axis_tdata_i[71:48];
      py_q    <= s_axis_tdata_i[95:72];
      pz_q    <= s_axis_tdata_i[119:96];
    end
    if (state_q == ST_DECIDE) begin
      last_x_q <= px_q;
      last_y_q <= py_q;
      last_z_q <= pz_q;
    end
    prod_q <= mag[MAG_W-1:0] * mag[MAG_W-1:0];
    acc_q  <= acc_d;
    if (out_load) begin
      out_det_q <= det_q;
      out_len_q <= run_count_q;
    end
  end

  // Square-root unit
  ppdd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (acc_d),
    .root_o  (root),
    .stat_o  (sq_stat)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_len_q, out_det_q};

  // Run counter stays in range
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_count_q <= CNT_W'(256))
    else $error("run counter out of range");

  // Root unit only runs while the sequencer waits for it
  a_root_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sq_stat.busy || sq_stat.done) |-> (state_q == ST_ROOT))
    else $error("square-root unit active outside root state");

  // An accepted request moves straight to the check
  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> (state_q == ST_CHECK))
    else $error("accepted request not checked");

  // A loaded result shows up on the output
  a_result_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid_o)
    else $error("result not presented");

endmodule

### hdl/ppdd_isqrt.sv
`timescale 1ns / 1ps
// Iterative integer square root, one result bit per cycle (restoring method).
// Depends on ppdd_pkg for widths and the status struct.
module ppdd_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ppdd_pkg::RAD_W-1:0]   rad_i,
  output logic [ppdd_pkg::ROOT_W-1:0]  root_o,
  output ppdd_pkg::sqrt_stat_t         stat_o
);
  import ppdd_pkg::*;

  localparam int ITER_W = $clog2(ROOT_W);

  logic [RAD_W-1:0]  rad_q, rad_d;
  logic [ROOT_W:0]   rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;

  // Bring down the next two radicand bits and try to append a one bit
  always_comb begin
    rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    iter_d = iter_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      iter_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = rad_q << 2;
      if (rem_sh >= trial) begin
        rem_d  = (ROOT_W+1)'(rem_sh - trial);
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = (ROOT_W+1)'(rem_sh);
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
      iter_d = iter_q + 1'b1;
      if (iter_q == ITER_W'(ROOT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control flags under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      iter_q <= iter_d;
    end
  end

  // Advance the working registers
  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o      = root_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

### test/tb_pointing_pose_dwell_detector.sv
`timescale 1ns / 1ps
// Self-checking bench for pointing_pose_dwell_detector: frame requests in, one result each.
// Predicts every result in-bench and compares field by field; depends on ppdd_pkg and the RTL.
module tb_pointing_pose_dwell_detector;
  import ppdd_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam logic signed [23:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] COORD_MIN = 24'sh800000;

  typedef struct {
    logic              empty;
    logic signed [23:0] hip;
    logic signed [23:0] elbow;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
  } pose_frame_t;

  typedef struct {
    logic       detected;
    logic [8:0] run_len;
  } pose_result_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [119:0] s_axis_tdata_i;
  logic         s_axis_tuser_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [15:0]  m_axis_tdata_o;
  logic         cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Predictor state and its copy of the registers
  logic [8:0]         dwell_count;
  logic [31:0]        motion_total;
  logic signed [23:0] prev_x, prev_y, prev_z;
  logic signed [23:0] hip_thr, elbow_thr;
  logic [7:0]         count_thr;
  logic [22:0]        still_thr;

  // Hand position of the run being generated
  logic signed [23:0] walk_x, walk_y, walk_z;

  pose_result_t pose_expect_q[$];
  int           fail_count;
  int           cycle_count;
  bit           steady;

  pointing_pose_dwell_detector i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stall the result side at random, except in the steady stretch
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready_i = steady || ($urandom_range(99) >= 14);
    end
  end

  // Compare each result with the oldest prediction
  always @(posedge clk_i) begin
    pose_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pose_expect_q.size() == 0) begin
        $error("unexpected result: detected %0d run_length %0d",
               m_axis_tdata_o[0], m_axis_tdata_o[9:1]);
        fail_count++;
      end else begin
        want = pose_expect_q.pop_front();
        if (m_axis_tdata_o[0] !== want.detected) begin
          $error("detected mismatch: expected %0d actual %0d",
                 want.detected, m_axis_tdata_o[0]);
          fail_count++;
        end
        if (m_axis_tdata_o[9:1] !== want.run_len) begin
          $error("run_length mismatch: expected %0d actual %0d",
                 want.run_len, m_axis_tdata_o[9:1]);
          fail_count++;
        end
      end
    end
  end

  function automatic longint unsigned sq_dist(logic signed [23:0] a, logic signed [23:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return d * d;
  endfunction

  // Floor square root, one result bit at a time from the top
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned trial;
    r = 0;
    for (int b = 25; b >= 0; b--) begin
      trial = r | (64'd1 << b);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  // Advance the dwell state by one frame and return the result it gives
  function automatic pose_result_t predict_pose(pose_frame_t f);
    pose_result_t     res;
    longint unsigned  total;
    res.detected = 1'b0;
    if (!f.empty) begin
      if (f.hip > hip_thr && f.elbow > elbow_thr) begin
        dwell_count = dwell_count + 9'd1;
        if (dwell_count > 9'd1) begin
          total = longint'(motion_total) + root_floor(sq_dist(f.x, prev_x) +
                  sq_dist(f.y, prev_y) + sq_dist(f.z, prev_z));
          motion_total = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(total);
        end
        prev_x = f.x;
        prev_y = f.y;
        prev_z = f.z;
        if (dwell_count > {1'b0, count_thr}) begin
          res.detected = (motion_total < {9'd0, still_thr});
          dwell_count  = '0;
          motion_total = '0;
        end
      end else begin
        dwell_count  = '0;
        motion_total = '0;
      end
    end
    res.run_len = dwell_count;
    return res;
  endfunction

  function automatic pose_frame_t mk_frame(bit empty, logic signed [23:0] hip,
                                           logic signed [23:0] elbow, logic signed [23:0] x,
                                           logic signed [23:0] y, logic signed [23:0] z);
    pose_frame_t f;
    f.empty = empty;
    f.hip   = hip;
    f.elbow = elbow;
    f.x     = x;
    f.y     = y;
    f.z     = z;
    return f;
  endfunction

  // Value strictly above a threshold, mostly close to it
  function automatic logic signed [23:0] pick_above(logic signed [23:0] thr);
    int lo;
    int span;
    if (thr == COORD_MAX) return 24'($urandom);
    lo   = int'(thr) + 1;
    span = 8388607 - lo;
    if ($urandom_range(3) == 0) return 24'(lo + int'($urandom_range(span)));
    return 24'(lo + int'($urandom_range(span < 255 ? span : 255)));
  endfunction

  // Value at or below a threshold
  function automatic logic signed [23:0] pick_at_most(logic signed [23:0] thr);
    int span;
    span = int'(thr) + 8388608;
    if ($urandom_range(3) == 0) return 24'(-8388608 + int'($urandom_range(span)));
    return 24'(int'(thr) - int'($urandom_range(span < 255 ? span : 255)));
  endfunction

  // Send one frame request, with random idle cycles in front of it
  task automatic send_frame(pose_frame_t f);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 14) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = f.empty;
    s_axis_tdata_i  = {f.z, f.y, f.x, f.elbow, f.hip};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pose_expect_q = {pose_expect_q, predict_pose(f)};
  endtask

  // Drop the request and hold until every result is back
  task automatic wait_drain();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (pose_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [23:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_addr_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_HAND_HIP:  hip_thr   = val;
      CFG_ELBOW:     elbow_thr = val;
      CFG_FRAME_CNT: count_thr = val[7:0];
      CFG_STILL:     still_thr = val[22:0];
      default: ;
    endcase
  endtask

  task automatic load_config(logic signed [23:0] hip, logic signed [23:0] elbow,
                             logic [7:0] cnt, logic [22:0] still);
    write_reg(CFG_HAND_HIP, hip);
    write_reg(CFG_ELBOW, elbow);
    write_reg(CFG_FRAME_CNT, {16'd0, cnt});
    write_reg(CFG_STILL, {1'b0, still});
  endtask

  // Qualifying frames with hand jitter; optionally broken halfway by a failing frame
  task automatic send_run(int len, int jitter, bit broken, output int sent);
    pose_frame_t f;
    sent   = 0;
    walk_x = 24'($urandom);
    walk_y = 24'($urandom);
    walk_z = 24'($urandom);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0)
        send_frame(mk_frame(1'b1, 24'($urandom), 24'($urandom), 24'($urandom),
                            24'($urandom), 24'($urandom)));
      if (broken && i == len / 2) begin
        case ($urandom_range(2))
          0: f = mk_frame(1'b0, pick_at_most(hip_thr), pick_above(elbow_thr),
                          walk_x, walk_y, walk_z);
          1: f = mk_frame(1'b0, pick_above(hip_thr), pick_at_most(elbow_thr),
                          walk_x, walk_y, walk_z);
          default: f = mk_frame(1'b0, pick_at_most(hip_thr), pick_at_most(elbow_thr),
                                walk_x, walk_y, walk_z);
        endcase
      end else begin
        walk_x = 24'(walk_x + (int'($urandom_range(2 * jitter)) - jitter));
        walk_y = 24'(walk_y + (int'($urandom_range(2 * jitter)) - jitter));
        walk_z = 24'(walk_z + (int'($urandom_range(2 * jitter)) - jitter));
        f = mk_frame(1'b0, pick_above(hip_thr), pick_above(elbow_thr), walk_x, walk_y, walk_z);
      end
      send_frame(f);
      sent++;
    end
  endtask

  // A few frames with every field random
  task automatic send_noise(output int sent);
    pose_frame_t f;
    int          n;
    sent = 0;
    n    = $urandom_range(4, 1);
    for (int i = 0; i < n; i++) begin
      f = mk_frame(1'($urandom_range(1)), 24'($urandom), 24'($urandom), 24'($urandom),
                   24'($urandom), 24'($urandom));
      send_frame(f);
      if (!f.empty) sent++;
    end
  endtask

  // Defaults, threshold edges, empty and failing frames, stillness boundary
  task automatic test_directed();
    // Default setup decides on every qualifying frame with zero movement
    send_frame(mk_frame(1'b0, 24'sd1, 24'sd1, 24'sd0, 24'sd0, 24'sd0));
    send_frame(mk_frame(1'b1, 24'sd5, 24'sd5, 24'sd7, 24'sd7, 24'sd7));
    send_frame(mk_frame(1'b0, 24'sd0, COORD_MAX, 24'sd0, 24'sd0, 24'sd0));
    send_frame(mk_frame(1'b0, COORD_MAX, 24'sd0, 24'sd0, 24'sd0, 24'sd0));
    send_frame(mk_frame(1'b0, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN));
    send_frame(mk_frame(1'b0, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
    wait_drain();

    // Default stillness limit: movement one below, then equal
    write_reg(CFG_FRAME_CNT, 24'd1);
    send_frame(mk_frame(1'b0, 24'sd1, 24'sd1, 24'sd0, 24'sd0, 24'sd0));
    send_frame(mk_frame(1'b0, 24'sd1, 24'sd1, 24'sd1842, 24'sd0, 24'sd0));
    send_frame(mk_frame(1'b0, 24'sd1, 24'sd1, 24'sd0, 24'sd0, 24'sd0));
    send_frame(mk_frame(1'b0, 24'sd1, 24'sd1, 24'sd1843, 24'sd0, 24'sd0));
    // Largest step on all three axes
    send_frame(mk_frame(1'b0, 24'sd1, 24'sd1, COORD_MIN, COORD_MIN, COORD_MIN));
    send_frame(mk_frame(1'b0, 24'sd1, 24'sd1, COORD_MAX, COORD_MAX, COORD_MAX));
    wait_drain();

    // Still run with an empty frame inside, then a run broken by a failing frame
    load_config(-24'sd100, 24'sd100, 8'd3, 23'd2000);
    send_frame(mk_frame(1'b0, -24'sd99, 24'sd101, 24'sd10, 24'sd10, 24'sd10));
    send_frame(mk_frame(1'b0, -24'sd99, 24'sd101, 24'sd12, 24'sd10, 24'sd10));
    send_frame(mk_frame(1'b1, COORD_MIN, COORD_MIN, 24'sd0, 24'sd0, 24'sd0));
    send_frame(mk_frame(1'b0, -24'sd99, 24'sd101, 24'sd12, 24'sd15, 24'sd10));
    send_frame(mk_frame(1'b0, -24'sd99, 24'sd101, 24'sd12, 24'sd15, 24'sd9));
    send_frame(mk_frame(1'b0, 24'sd50, 24'sd200, 24'sd0, 24'sd0, 24'sd0));
    send_frame(mk_frame(1'b0, 24'sd50, 24'sd200, 24'sd3, 24'sd4, 24'sd0));
    send_frame(mk_frame(1'b0, -24'sd100, 24'sd200, 24'sd3, 24'sd4, 24'sd0));
    send_frame(mk_frame(1'b0, 24'sd50, 24'sd200, 24'sd3, 24'sd4, 24'sd0));
    wait_drain();

    // Thresholds at the ends of their range
    load_config(COORD_MAX, COORD_MIN, 8'd0, 23'h7FFFFF);
    send_frame(mk_frame(1'b0, COORD_MAX, COORD_MAX, 24'sd0, 24'sd0, 24'sd0));
    wait_drain();
    load_config(COORD_MIN, COORD_MIN, 8'd0, 23'd0);
    send_frame(mk_frame(1'b0, COORD_MIN + 24'sd1, COORD_MIN + 24'sd1, 24'sd1, 24'sd2, 24'sd3));
    send_frame(mk_frame(1'b0, COORD_MIN, COORD_MAX, 24'sd1, 24'sd2, 24'sd3));
    wait_drain();
  endtask

  // Longest run with the hand jumping corner to corner: the movement sum saturates
  task automatic test_saturation();
    logic signed [23:0] c;
    load_config(COORD_MIN, COORD_MIN, 8'hFF, 23'h7FFFFF);
    for (int i = 0; i < 256; i++) begin
      c = i[0] ? COORD_MAX : COORD_MIN;
      send_frame(mk_frame(1'b0, COORD_MAX, COORD_MAX, c, c, c));
    end
    wait_drain();
  endtask

  // Mostly well-formed runs with random content under several register settings
  task automatic test_random();
    int         done;
    int         target;
    int         len;
    int         jitter;
    int         n;
    logic [7:0] cnt;
    for (int p = 0; p < 9; p++) begin
      wait_drain();
      steady = (p == 2);
      cnt    = ($urandom_range(5) == 0) ? 8'($urandom_range(60, 30)) : 8'($urandom_range(15));
      case (p)
        0: load_config(COORD_MIN, COORD_MIN, 8'd0, 23'h7FFFFF);
        8: load_config(COORD_MAX, COORD_MAX, 8'hFF, 23'd0);
        default: begin
          if ($urandom_range(3) == 0)
            load_config(24'($urandom), 24'($urandom), cnt, 23'($urandom));
          else
            load_config(24'(int'($urandom_range(4000)) - 2000),
                        24'(int'($urandom_range(4000)) - 2000), cnt,
                        23'($urandom_range(20000)));
        end
      endcase
      target = (p == 8) ? 20 : 36;
      done   = 0;
      while (done < target) begin
        n = 0;
        case ($urandom_range(7))
          0:       jitter = 0;
          5, 6:    jitter = $urandom_range(100000);
          7:       jitter = ($urandom_range(3) == 0) ? 8388607 : $urandom_range(3000);
          default: jitter = $urandom_range(300, 1);
        endcase
        len = $urandom_range(1) ? int'(count_thr) + 1 : $urandom_range(int'(count_thr) + 2, 1);
        case ($urandom_range(19))
          0, 1:    send_noise(n);
          2, 3, 4: send_run(len < 2 ? 2 : len, jitter, 1'b1, n);
          default: send_run(len, jitter, 1'b0, n);
        endcase
        done += n;
        // Hold off now and then until the block has caught up
        if ($urandom_range(11) == 0) wait_drain();
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_addr_i      = CFG_HAND_HIP;
    cfg_data_i      = '0;
    steady          = 1'b0;
    fail_count      = 0;
    cycle_count     = 0;
    dwell_count     = '0;
    motion_total    = '0;
    prev_x          = '0;
    prev_y          = '0;
    prev_z          = '0;
    hip_thr         = '0;
    elbow_thr       = '0;
    count_thr       = '0;
    still_thr       = 23'd1843;
    walk_x          = '0;
    walk_y          = '0;
    walk_z          = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_saturation();
    test_random();

    // Let the last frame settle, then close out
    wait_drain();
    repeat (60) @(posedge clk_i);
    if (pose_expect_q.size() != 0) begin
      $error("%0d results never arrived", pose_expect_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
